[hdl/range_scan_point_converter_macros.svh]
// Assertion macros shared by the range scan point converter modules.
`ifndef RANGE_SCAN_POINT_CONVERTER_MACROS_SVH
`define RANGE_SCAN_POINT_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define RSPC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rspc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RSPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rspc: next-cycle check failed");

`else

`define RSPC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RSPC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hdl/rspc_pkg.sv]
// Shared types, register codes and constants of the range scan point converter.
`timescale 1ns / 1ps

package rspc_pkg;

   // Field widths.
   localparam int DIST_W      = 16;
   localparam int OFFSET_W    = 12;
   localparam int TOL_W       = 12;
   localparam int STEP_W      = 8;
   localparam int ANGLE_OUT_W = 8;
   // Internal angle width; holds a sweep end of up to a full turn.
   localparam int ANGLE_W     = 9;
   localparam int X_W         = 17;
   localparam int TRIG_W      = 16;
   localparam int TRIG_IDX_W  = 7;

   // Configuration port.
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SENSOR_MODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOUNT_OFFSET    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AGREE_TOLERANCE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_RANGE       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RANGE       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_STEP      = 3'd5;

   // Register reset values.
   localparam logic                RST_SENSOR_MODE     = 1'b0;
   localparam logic [OFFSET_W-1:0] RST_MOUNT_OFFSET    = 12'd112;
   localparam logic [TOL_W-1:0]    RST_AGREE_TOLERANCE = 12'd160;
   localparam logic [DIST_W-1:0]   RST_MIN_RANGE       = 16'd160;
   localparam logic [DIST_W-1:0]   RST_MAX_RANGE       = 16'd1600;
   localparam logic [STEP_W-1:0]   RST_ANGLE_STEP      = 8'd3;

   // Item function and sensor mode codes.
   localparam logic FUNC_START      = 1'b0;
   localparam logic MODE_LASER      = 1'b0;
   localparam logic MODE_ULTRASONIC = 1'b1;

   // Readings combined into one ultrasonic point.
   localparam int SAMPLES_PER_POINT = 3;

   // floor(s/3) = (s * MEAN3_RECIP) >> MEAN3_SHIFT for every s below 2**19.
   localparam int MEAN3_SUM_W = DIST_W + 2;
   localparam int MEAN3_SHIFT = 19;
   localparam logic [MEAN3_SUM_W-1:0] MEAN3_RECIP = 18'd174763;

   // Q1.15 trig scaling with round half up.
   localparam int TRIG_FRAC_BITS = 15;
   localparam logic [2*DIST_W:0] ROUND_HALF = 33'd16384;

   // Angle folding points in degrees.
   localparam logic [ANGLE_W-1:0] DEG_90  = 9'd90;
   localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
   localparam logic [ANGLE_W-1:0] DEG_270 = 9'd270;
   localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

   // Quarter-wave sine, Q1.15 magnitudes, 1.0 held as 32768.
   localparam logic [TRIG_W-1:0] QUARTER_SINE [0:90] = '{
      16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
      16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
      16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
      16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
      16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
      16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
      16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
      16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
      16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
      16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
      16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
      16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
      16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
   };

   typedef struct packed {
      logic                sensor_mode;
      logic [OFFSET_W-1:0] mount_offset;
      logic [TOL_W-1:0]    agree_tolerance;
      logic [DIST_W-1:0]   min_range;
      logic [DIST_W-1:0]   max_range;
      logic [STEP_W-1:0]   angle_step;
   } cfg_type;

   // One point job: a laser job carries its distance in all three readings.
   typedef struct packed {
      logic               multi;
      logic [DIST_W-1:0]  a;
      logic [DIST_W-1:0]  b;
      logic [DIST_W-1:0]  c;
      logic [ANGLE_W-1:0] angle;
      logic               last;
   } job_type;

   typedef struct packed {
      logic signed [X_W-1:0]  x_offset;
      logic [DIST_W-1:0]      y_offset;
      logic [DIST_W-1:0]      point_distance;
      logic [ANGLE_OUT_W-1:0] angle_degrees;
      logic                   point_valid;
      logic                   last_point;
   } result_type;

endpackage

[hdl/rspc_fifo.sv]
// Small register queue used between the front and back parts and at the result side.
`timescale 1ns / 1ps
`include "range_scan_point_converter_macros.svh"

module rspc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             wr_en;
   logic             rd_en;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign wr_en = push && !full;
   assign rd_en = pop && !empty;
   assign rdata = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

   `RSPC_ASSERT_NEXT(a_fifo_count_up, clock, reset, wr_en && !rd_en, count_ff == $past(count_ff) + 1'b1)

endmodule

[hdl/rspc_front.sv]
// Front part: takes items, tracks the sweep and ultrasonic samples, and issues point jobs.
`timescale 1ns / 1ps
`include "range_scan_point_converter_macros.svh"

module rspc_front import rspc_pkg::*; #(
   parameter int TRIG_TABLE_ENTRIES = 181
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_push,
   input  logic              req_func,
   input  logic [DIST_W-1:0] req_raw_distance,
   input  logic              job_full,
   output logic              job_push,
   output job_type           job_data
);

   localparam int SWEEP_END = TRIG_TABLE_ENTRIES - 1;

   logic                scan_active_ff, scan_active_in;
   logic [STEP_W-1:0]   point_index_ff, point_index_in;
   logic [1:0]          sample_count_ff, sample_count_in;
   logic [DIST_W-1:0]   held_ff [2];
   logic                held_wr;

   logic                accept;
   logic [DIST_W:0]     dist_sum;
   logic [DIST_W-1:0]   dist_corr;
   logic [STEP_W-1:0]   step_eff;
   logic [2*STEP_W-1:0] angle_prod;
   logic [ANGLE_W-1:0]  angle;
   logic [ANGLE_W:0]    angle_next;
   logic                last;
   logic                multi;

   assign accept = req_push && !job_full;

   // Mount offset added with saturation at full scale.
   assign dist_sum  = {1'b0, req_raw_distance} + {{(DIST_W + 1 - OFFSET_W){1'b0}}, cfg.mount_offset};
   assign dist_corr = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];

   assign step_eff   = (cfg.angle_step == '0) ? STEP_W'(1) : cfg.angle_step;
   assign angle_prod = {{STEP_W{1'b0}}, point_index_ff} * {{STEP_W{1'b0}}, step_eff};
   assign angle      = (angle_prod > (2*STEP_W)'(SWEEP_END)) ? ANGLE_W'(SWEEP_END)
                                                            : angle_prod[ANGLE_W-1:0];
   assign angle_next = {1'b0, angle} + (ANGLE_W + 1)'(step_eff);
   assign last       = (angle_next > (ANGLE_W + 1)'(SWEEP_END));
   assign multi      = (cfg.sensor_mode == MODE_ULTRASONIC);

   // A laser job carries the one reading in every slot.
   always_comb begin
      job_data.multi = multi;
      job_data.a     = multi ? held_ff[0] : dist_corr;
      job_data.b     = multi ? held_ff[1] : dist_corr;
      job_data.c     = dist_corr;
      job_data.angle = angle;
      job_data.last  = last;
   end

   always_comb begin
      scan_active_in  = scan_active_ff;
      point_index_in  = point_index_ff;
      sample_count_in = sample_count_ff;
      held_wr         = 1'b0;
      job_push        = 1'b0;
      if (accept) begin
         if (req_func == FUNC_START) begin
            scan_active_in  = 1'b1;
            point_index_in  = '0;
            sample_count_in = '0;
         end else if (scan_active_ff) begin
            if (!multi || (sample_count_ff == 2'(SAMPLES_PER_POINT - 1))) begin
               sample_count_in = '0;
               job_push        = 1'b1;
               point_index_in  = last ? '0 : point_index_ff + 1'b1;
               scan_active_in  = !last;
            end else begin
               held_wr         = 1'b1;
               sample_count_in = sample_count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_active_ff  <= 1'b0;
         point_index_ff  <= '0;
         sample_count_ff <= '0;
      end else begin
         scan_active_ff  <= scan_active_in;
         point_index_ff  <= point_index_in;
         sample_count_ff <= sample_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (held_wr) begin
         held_ff[sample_count_ff[0]] <= dist_corr;
      end
   end

   `RSPC_ASSERT_IMPLY(a_job_in_sweep, clock, reset, job_push, scan_active_ff)
   `RSPC_ASSERT_NEXT(a_last_closes_sweep, clock, reset, job_push && job_data.last, !scan_active_ff && (point_index_ff == '0))

endmodule

[hdl/rspc_back.sv]
// Back part: consensus, range gate and polar to plane conversion, four stages deep.
`timescale 1ns / 1ps
`include "range_scan_point_converter_macros.svh"

module rspc_back import rspc_pkg::*; #(
   parameter int RSP_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       job_empty,
   input  job_type    job_data,
   output logic       job_pop,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output result_type rsp_data
);

   localparam int PROD_W = 2 * DIST_W;

   logic en;
   logic rsp_full;
   logic rsp_push;

   // Stage 1: distances between readings and sums.
   logic                   s1_valid_ff;
   logic                   s1_multi_ff;
   logic [DIST_W-1:0]      s1_a_ff;
   logic [DIST_W-1:0]      s1_dab_ff, s1_dca_ff, s1_dcb_ff;
   logic [MEAN3_SUM_W-1:0] s1_sum3_ff;
   logic [DIST_W:0]        s1_sum_ab_ff, s1_sum_ac_ff, s1_sum_bc_ff;
   logic [ANGLE_W-1:0]     s1_angle_ff;
   logic                   s1_last_ff;

   // Stage 2: rule outcome and scaled sum of three.
   logic                     s2_valid_ff;
   logic                     s2_ok_ff;
   logic                     s2_use_mean3_ff;
   logic [DIST_W-1:0]        s2_pair_ff;
   logic [2*MEAN3_SUM_W-1:0] s2_prod_ff;
   logic [ANGLE_W-1:0]       s2_angle_ff;
   logic                     s2_last_ff;

   // Stage 3: final distance, gate and trig magnitudes.
   logic                s3_valid_ff;
   logic [DIST_W-1:0]   s3_d_ff;
   logic                s3_in_range_ff;
   logic [TRIG_W-1:0]   s3_smag_ff, s3_cmag_ff;
   logic                s3_sneg_ff, s3_cneg_ff;
   logic [ANGLE_W-1:0]  s3_angle_ff;
   logic                s3_last_ff;

   // Stage 4: products.
   logic                s4_valid_ff;
   logic [PROD_W-1:0]   s4_ymul_ff, s4_xmul_ff;
   logic [DIST_W-1:0]   s4_d_ff;
   logic                s4_in_range_ff;
   logic                s4_sneg_ff, s4_cneg_ff;
   logic [ANGLE_W-1:0]  s4_angle_ff;
   logic                s4_last_ff;

   assign en       = !(s4_valid_ff && rsp_full);
   assign job_pop  = !job_empty && en;
   assign rsp_push = s4_valid_ff;

   // ---- stage 1 logic
   logic [DIST_W-1:0] dab, dca, dcb;

   assign dab = (job_data.a > job_data.b) ? job_data.a - job_data.b : job_data.b - job_data.a;
   assign dca = (job_data.c > job_data.a) ? job_data.c - job_data.a : job_data.a - job_data.c;
   assign dcb = (job_data.c > job_data.b) ? job_data.c - job_data.b : job_data.b - job_data.c;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_multi_ff  <= job_data.multi;
         s1_a_ff      <= job_data.a;
         s1_dab_ff    <= dab;
         s1_dca_ff    <= dca;
         s1_dcb_ff    <= dcb;
         s1_sum3_ff   <= MEAN3_SUM_W'(job_data.a) + MEAN3_SUM_W'(job_data.b)
                       + MEAN3_SUM_W'(job_data.c);
         s1_sum_ab_ff <= {1'b0, job_data.a} + {1'b0, job_data.b};
         s1_sum_ac_ff <= {1'b0, job_data.a} + {1'b0, job_data.c};
         s1_sum_bc_ff <= {1'b0, job_data.b} + {1'b0, job_data.c};
         s1_angle_ff  <= job_data.angle;
         s1_last_ff   <= job_data.last;
      end
   end

   // ---- stage 2 logic: later rules take precedence over earlier ones.
   logic [DIST_W-1:0] tol;
   logic              r_all, r_bc, r_ac, r_ab;
   logic              ok2, use_mean3_2;
   logic [DIST_W-1:0] pair2;

   assign tol   = {{(DIST_W - TOL_W){1'b0}}, cfg.agree_tolerance};
   assign r_all = (s1_dab_ff < tol) && (s1_dca_ff < tol);
   assign r_bc  = (s1_dab_ff > tol) && (s1_dcb_ff < tol);
   assign r_ac  = (s1_dab_ff > tol) && (s1_dca_ff < tol);
   assign r_ab  = (s1_dca_ff > tol) && (s1_dab_ff < tol);

   always_comb begin
      ok2         = 1'b1;
      use_mean3_2 = 1'b0;
      pair2       = s1_a_ff;
      if (s1_multi_ff) begin
         if (r_ab) begin
            pair2 = s1_sum_ab_ff[DIST_W:1];
         end else if (r_ac) begin
            pair2 = s1_sum_ac_ff[DIST_W:1];
         end else if (r_bc) begin
            pair2 = s1_sum_bc_ff[DIST_W:1];
         end else if (r_all) begin
            use_mean3_2 = 1'b1;
         end else begin
            ok2 = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ok_ff        <= ok2;
         s2_use_mean3_ff <= use_mean3_2;
         s2_pair_ff      <= pair2;
         s2_prod_ff      <= {{MEAN3_SUM_W{1'b0}}, s1_sum3_ff}
                          * {{MEAN3_SUM_W{1'b0}}, MEAN3_RECIP};
         s2_angle_ff     <= s1_angle_ff;
         s2_last_ff      <= s1_last_ff;
      end
   end

   // ---- stage 3 logic
   logic [DIST_W-1:0]  d3;
   logic [ANGLE_W-1:0] ang;
   logic [ANGLE_W-1:0] sidx, cidx;
   logic               sneg3, cneg3;

   always_comb begin
      if (!s2_ok_ff) begin
         d3 = '0;
      end else if (s2_use_mean3_ff) begin
         d3 = s2_prod_ff[MEAN3_SHIFT +: DIST_W];
      end else begin
         d3 = s2_pair_ff;
      end
   end

   // Fold the angle onto the quarter-wave table.
   always_comb begin
      ang = (s2_angle_ff == DEG_360) ? '0 : s2_angle_ff;
      if (ang <= DEG_90) begin
         sidx = ang;           sneg3 = 1'b0;
         cidx = DEG_90 - ang;  cneg3 = 1'b0;
      end else if (ang <= DEG_180) begin
         sidx = DEG_180 - ang; sneg3 = 1'b0;
         cidx = ang - DEG_90;  cneg3 = 1'b1;
      end else if (ang <= DEG_270) begin
         sidx = ang - DEG_180; sneg3 = 1'b1;
         cidx = DEG_270 - ang; cneg3 = 1'b1;
      end else begin
         sidx = DEG_360 - ang; sneg3 = 1'b1;
         cidx = ang - DEG_270; cneg3 = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_d_ff        <= d3;
         s3_in_range_ff <= s2_ok_ff && (d3 >= cfg.min_range) && (d3 <= cfg.max_range);
         s3_smag_ff     <= QUARTER_SINE[sidx[TRIG_IDX_W-1:0]];
         s3_cmag_ff     <= QUARTER_SINE[cidx[TRIG_IDX_W-1:0]];
         s3_sneg_ff     <= sneg3;
         s3_cneg_ff     <= cneg3;
         s3_angle_ff    <= s2_angle_ff;
         s3_last_ff     <= s2_last_ff;
      end
   end

   // ---- stage 4: products
   always_ff @(posedge clock) begin
      if (en) begin
         s4_ymul_ff     <= {{DIST_W{1'b0}}, s3_smag_ff} * {{TRIG_W{1'b0}}, s3_d_ff};
         s4_xmul_ff     <= {{DIST_W{1'b0}}, s3_cmag_ff} * {{TRIG_W{1'b0}}, s3_d_ff};
         s4_d_ff        <= s3_d_ff;
         s4_in_range_ff <= s3_in_range_ff;
         s4_sneg_ff     <= s3_sneg_ff;
         s4_cneg_ff     <= s3_cneg_ff;
         s4_angle_ff    <= s3_angle_ff;
         s4_last_ff     <= s3_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= job_pop;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // ---- rounding, saturation and signs into the result queue
   logic [PROD_W:0]   yround, xround;
   logic [DIST_W-1:0] ymag, xmag;
   logic [X_W-1:0]    xmag_ext;
   result_type        res;

   assign yround = {1'b0, s4_ymul_ff} + ROUND_HALF;
   assign xround = {1'b0, s4_xmul_ff} + ROUND_HALF;

   always_comb begin
      ymag = (yround[PROD_W:TRIG_FRAC_BITS + DIST_W] != '0) ? '1
           : yround[TRIG_FRAC_BITS +: DIST_W];
      xmag = (xround[PROD_W:TRIG_FRAC_BITS + DIST_W] != '0) ? '1
           : xround[TRIG_FRAC_BITS +: DIST_W];
      if (s4_sneg_ff) begin
         ymag = '0;
      end
      xmag_ext           = {1'b0, xmag};
      res.x_offset       = s4_cneg_ff ? $signed(xmag_ext) : $signed(-xmag_ext);
      res.y_offset       = ymag;
      res.point_distance = s4_d_ff;
      res.angle_degrees  = s4_angle_ff[ANGLE_OUT_W-1:0];
      res.point_valid    = s4_in_range_ff;
      res.last_point     = s4_last_ff;
   end

   logic [$bits(result_type)-1:0] rsp_rdata;

   rspc_fifo #(
      .WIDTH($bits(result_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (res),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_rdata),
      .empty (rsp_empty)
   );

   assign rsp_data = result_type'(rsp_rdata);

   `RSPC_ASSERT_NEXT(a_stall_keeps_point, clock, reset, s4_valid_ff && rsp_full, s4_valid_ff)

endmodule

[hdl/range_scan_point_converter.sv]
// Top level of the range scan point converter: register file, front, job queue and back.
`timescale 1ns / 1ps
// A reading that completes a point passes the job queue, back stages and result queue.
// Throughput: one item per cycle; req_full only rises when results are not popped and the
// job queue (JOB_DEPTH entries) and result queue (RSP_DEPTH entries) have filled.
// Start items and readings that only fill an ultrasonic sample produce no result.
// Reset is synchronous: sweep state, queues and stage valids clear and registers reload defaults.

module range_scan_point_converter import rspc_pkg::*; #(
   parameter int TRIG_TABLE_ENTRIES = 181,
   parameter int JOB_DEPTH          = 4,
   parameter int RSP_DEPTH          = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   // Configuration writes.
   input  logic                          csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   // Input items.
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_func,
   input  logic [DIST_W-1:0]             req_raw_distance,
   // Result items.
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [X_W-1:0]         rsp_x_offset,
   output logic [DIST_W-1:0]             rsp_y_offset,
   output logic [DIST_W-1:0]             rsp_point_distance,
   output logic [ANGLE_OUT_W-1:0]        rsp_angle_degrees,
   output logic                          rsp_point_valid,
   output logic                          rsp_last_point
);

   // The register file. Writes are expected only while the block is idle, so both
   // parts simply read the live values.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SENSOR_MODE:     cfg_in.sensor_mode     = csr_wdata[0];
            CSR_MOUNT_OFFSET:    cfg_in.mount_offset    = csr_wdata[OFFSET_W-1:0];
            CSR_AGREE_TOLERANCE: cfg_in.agree_tolerance = csr_wdata[TOL_W-1:0];
            CSR_MIN_RANGE:       cfg_in.min_range       = csr_wdata[DIST_W-1:0];
            CSR_MAX_RANGE:       cfg_in.max_range       = csr_wdata[DIST_W-1:0];
            CSR_ANGLE_STEP:      cfg_in.angle_step      = csr_wdata[STEP_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_mode     <= RST_SENSOR_MODE;
         cfg_ff.mount_offset    <= RST_MOUNT_OFFSET;
         cfg_ff.agree_tolerance <= RST_AGREE_TOLERANCE;
         cfg_ff.min_range       <= RST_MIN_RANGE;
         cfg_ff.max_range       <= RST_MAX_RANGE;
         cfg_ff.angle_step      <= RST_ANGLE_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front part handles every item in the cycle it is taken: it tracks the sweep
   // position and held ultrasonic samples and turns each completed point into a job.
   logic    job_push;
   logic    job_full;
   logic    job_pop;
   logic    job_empty;
   job_type job_wdata;
   logic [$bits(job_type)-1:0] job_rdata;

   assign req_full = job_full;

   rspc_front #(
      .TRIG_TABLE_ENTRIES(TRIG_TABLE_ENTRIES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_push         (req_push),
      .req_func         (req_func),
      .req_raw_distance (req_raw_distance),
      .job_full         (job_full),
      .job_push         (job_push),
      .job_data         (job_wdata)
   );

   // The job queue lets the front keep taking items while the back is stalled.
   rspc_fifo #(
      .WIDTH($bits(job_type)),
      .DEPTH(JOB_DEPTH)
   ) u_job_fifo (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .wdata (job_wdata),
      .full  (job_full),
      .pop   (job_pop),
      .rdata (job_rdata),
      .empty (job_empty)
   );

   // The back part runs consensus, the range gate and the trig products in a
   // stalling four-stage pipeline that ends in the result queue.
   result_type rsp_data;

   rspc_back #(
      .RSP_DEPTH(RSP_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_empty (job_empty),
      .job_data  (job_type'(job_rdata)),
      .job_pop   (job_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   assign rsp_x_offset       = rsp_data.x_offset;
   assign rsp_y_offset       = rsp_data.y_offset;
   assign rsp_point_distance = rsp_data.point_distance;
   assign rsp_angle_degrees  = rsp_data.angle_degrees;
   assign rsp_point_valid    = rsp_data.point_valid;
   assign rsp_last_point     = rsp_data.last_point;

endmodule
